### rtl/core/priority_stack_insert_pop_assert.svh
// Assertion macros for the priority stack.
`ifndef PRIORITY_STACK_INSERT_POP_ASSERT_SVH
`define PRIORITY_STACK_INSERT_POP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSI_ASSERT_SAME(name, clk_i, rst_n_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!(rst_n_i)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSI_ASSERT_NEXT(name, clk_i, rst_n_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!(rst_n_i)) \
		(ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/psi_pkg.sv
// Types and constants shared by the priority stack modules.
`default_nettype none

package psi_pkg;

	localparam int PSI_DEPTH  = 16;
	localparam int ELEM_BITS  = 32;
	localparam int PRIO_BITS  = 8;
	localparam int COUNT_BITS = 5;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef struct packed {
		op_t                  mode;
		logic [ELEM_BITS-1:0] elem_value;
		logic [PRIO_BITS-1:0] prio;
	} req_t;

	typedef struct packed {
		logic [ELEM_BITS-1:0]  front_elem;
		logic [PRIO_BITS-1:0]  front_prio;
		logic [COUNT_BITS-1:0] entry_count;
		logic                  is_empty;
		status_t               status;
	} rsp_t;

	typedef struct packed {
		logic [ELEM_BITS-1:0] elem;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic   push_en;
		logic   pop_en;
		entry_t ent;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/core/priority_stack_insert_pop.sv
// Top level of the priority stack: cell row, count and result register.
`default_nettype none

// Bounded priority stack built as a row of DEPTH cells, entry 0 at the front.
// Every cell compares its priority with the pushed one in parallel and then
// keeps, takes the new word or shifts by one, so each item, push or pop, is
// applied in one step and one word is accepted per cycle while the output register is free. The result
// word appears in the output register the cycle after acceptance; a new word
// is accepted whenever that register is empty or being taken in the same
// cycle. Push on a full store and pop on an empty store change nothing and
// are reported in the status field.
`include "priority_stack_insert_pop_assert.svh"

module priority_stack_insert_pop import psi_pkg::*; #(
	parameter int DEPTH = PSI_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	cmd_t             cmd;
	status_t          status;

	entry_t           ent_a [DEPTH];
	logic             gh_a  [DEPTH];
	entry_t           front_next;

	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		cmd.push_en  = accept && (req.mode == OP_PUSH) && !full;
		cmd.pop_en   = accept && (req.mode == OP_POP) && !empty;
		cmd.ent.elem = req.elem_value;
		cmd.ent.prio = req.prio;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left;
		logic   left_gh;
		entry_t right;
		entry_t nxt;

		if (i == 0) begin : g_first
			assign left    = cmd.ent;
			assign left_gh = 1'b0;
			assign front_next = nxt;
		end else begin : g_inner
			assign left    = ent_a[i-1];
			assign left_gh = gh_a[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = ent_a[i];
		end else begin : g_mid
			assign right = ent_a[i+1];
		end

		psi_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occ      (count_q > CNT_W'(i)),
			.left     (left),
			.left_gh  (left_gh),
			.right    (right),
			.ent      (ent_a[i]),
			.gh       (gh_a[i]),
			.ent_next (nxt)
		);
	end

	always_comb begin
		count_next = count_q;
		status     = ST_OK;
		if (cmd.push_en) begin
			count_next = count_q + 1'b1;
		end else if (cmd.pop_en) begin
			count_next = count_q - 1'b1;
		end
		if (req.mode == OP_PUSH && full) begin
			status = ST_PUSH_FULL;
		end else if (req.mode == OP_POP && empty) begin
			status = ST_POP_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.front_elem  <= (count_next != '0) ? front_next.elem : '0;
			rsp_q.front_prio  <= (count_next != '0) ? front_next.prio : '0;
			rsp_q.entry_count <= COUNT_BITS'(count_next);
			rsp_q.is_empty    <= (count_next == '0);
			rsp_q.status      <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PSI_ASSERT_NEXT(a_accept_gives_rsp, clk, arst_n, accept, rsp_valid, "accepted word gave no result")
	`PSI_ASSERT_NEXT(a_push_full_flag, clk, arst_n, accept && req.mode == OP_PUSH && full, rsp.status == ST_PUSH_FULL && count_q == $past(count_q), "push on full not flagged")
	`PSI_ASSERT_NEXT(a_pop_count, clk, arst_n, accept && req.mode == OP_POP && !empty, count_q == $past(count_q) - 1'b1, "pop did not drop the count by one")
	`PSI_ASSERT_SAME(a_empty_zero, clk, arst_n, rsp_valid && rsp.is_empty, rsp.entry_count == '0 && rsp.front_elem == '0 && rsp.front_prio == '0, "empty result carries data")

endmodule

`default_nettype wire

### rtl/core/psi_cell.sv
// One cell of the sorted store: holds an entry and shifts it on push or pop.
`default_nettype none

module psi_cell import psi_pkg::*; (
	input  logic   clk,
	input  cmd_t   cmd,
	input  logic   occ,
	input  entry_t left,
	input  logic   left_gh,
	input  entry_t right,
	output entry_t ent,
	output logic   gh,
	output entry_t ent_next
);

	entry_t ent_q;

	// The new entry belongs at or ahead of this cell unless a stored higher priority sits here.
	assign gh  = !(occ && (ent_q.prio > cmd.ent.prio));
	assign ent = ent_q;

	always_comb begin
		ent_next = ent_q;
		if (cmd.push_en && gh) begin
			ent_next = left_gh ? left : cmd.ent;
		end else if (cmd.pop_en) begin
			ent_next = right;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_next;
	end

endmodule

`default_nettype wire
